// ===== rtl/rpt_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rpt_pkg: shared constants and types of the rectangle patch tiler
// Field widths, register indexes and the controller/datapath interface.
// ----------------------------------------------------------------------------
package rpt_pkg;

  localparam int COORD_BITS   = 16;
  localparam int LEN_BITS     = COORD_BITS - 1;
  localparam int OUT_BITS     = COORD_BITS + 1;
  localparam int ARITH_BITS   = COORD_BITS + 2;
  localparam int PSIZE_BITS   = 13;
  localparam int MAX_PATCHES  = 64;
  localparam int CNT_BITS     = $clog2(MAX_PATCHES + 1);
  localparam int DIV_CNT_BITS = $clog2(COORD_BITS);

  localparam int CFG_IDX_BITS = 2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_PATCH_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_PATCH_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_TILING_MODE  = 2'd2;

  localparam logic MODE_GRID  = 1'b0;
  localparam logic MODE_TIGHT = 1'b1;

  localparam logic [PSIZE_BITS-1:0] PATCH_SIZE_RESET = 13'd256;

  typedef struct packed {
    logic load;
    logic div_start;
    logic div_sel_y;
    logic set_first_x;
    logic set_first_y;
    logic emit;
  } rpt_cmd_t;

  typedef struct packed {
    logic in_empty;
    logic div_done;
    logic out_free;
    logic last_patch;
  } rpt_sts_t;

endpackage
`default_nettype wire

// ===== rtl/rpt_divider.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rpt_divider: bit-serial remainder unit
// Restoring division of an unsigned magnitude by the patch size, one
// quotient bit per cycle; only the remainder is kept.
// ----------------------------------------------------------------------------
module rpt_divider
  import rpt_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start_i,
  input  wire logic [COORD_BITS-1:0] dividend_i,
  input  wire logic [PSIZE_BITS-1:0] divisor_i,
  output logic                       done_o,
  output logic [PSIZE_BITS-1:0]      rem_o
);

  logic                    active_q, active_d;
  logic                    done_q, done_d;
  logic [DIV_CNT_BITS-1:0] cnt_q, cnt_d;
  logic [COORD_BITS-1:0]   shift_q, shift_d;
  logic [PSIZE_BITS-1:0]   rem_q, rem_d;
  logic [PSIZE_BITS-1:0]   divisor_q, divisor_d;
  logic [PSIZE_BITS:0]     trial;
  logic [PSIZE_BITS:0]     diff;

  assign trial = {rem_q, shift_q[COORD_BITS-1]};
  assign diff  = trial - {1'b0, divisor_q};

  always_comb begin
    active_d  = active_q;
    done_d    = 1'b0;
    cnt_d     = cnt_q;
    shift_d   = shift_q;
    rem_d     = rem_q;
    divisor_d = divisor_q;
    if (start_i) begin
      active_d  = 1'b1;
      cnt_d     = DIV_CNT_BITS'(COORD_BITS - 1);
      shift_d   = dividend_i;
      rem_d     = '0;
      divisor_d = divisor_i;
    end else if (active_q) begin
      // remainder stays below the divisor, so it fits the patch size width
      rem_d   = (trial >= {1'b0, divisor_q}) ? diff[PSIZE_BITS-1:0]
                                             : trial[PSIZE_BITS-1:0];
      shift_d = {shift_q[COORD_BITS-2:0], 1'b0};
      cnt_d   = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        active_d = 1'b0;
        done_d   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      done_q   <= 1'b0;
      cnt_q    <= '0;
    end else begin
      active_q <= active_d;
      done_q   <= done_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    shift_q   <= shift_d;
    rem_q     <= rem_d;
    divisor_q <= divisor_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule
`default_nettype wire

// ===== rtl/rpt_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rpt_ctrl: sequencing state machine of the patch tiler
// Takes a rectangle, in grid mode runs the grid alignment divisions, then walks patches.
// ----------------------------------------------------------------------------
module rpt_ctrl
  import rpt_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  input  wire logic     mode_i,
  input  wire rpt_sts_t sts_i,
  output logic          in_stall_o,
  output rpt_cmd_t      cmd_o
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_XSTART = 3'd1;
  localparam logic [2:0] S_XWAIT  = 3'd2;
  localparam logic [2:0] S_YSTART = 3'd3;
  localparam logic [2:0] S_YWAIT  = 3'd4;
  localparam logic [2:0] S_EMIT   = 3'd5;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if (!sts_i.in_empty) begin
            state_d = (mode_i == MODE_TIGHT) ? S_EMIT : S_XSTART;
          end
        end
      end
      S_XSTART: begin
        cmd_o.div_start = 1'b1;
        state_d         = S_XWAIT;
      end
      S_XWAIT: begin
        if (sts_i.div_done) begin
          cmd_o.set_first_x = 1'b1;
          state_d           = S_YSTART;
        end
      end
      S_YSTART: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel_y = 1'b1;
        state_d         = S_YWAIT;
      end
      S_YWAIT: begin
        if (sts_i.div_done) begin
          cmd_o.set_first_y = 1'b1;
          state_d           = S_EMIT;
        end
      end
      S_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (sts_i.last_patch) begin
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

endmodule
`default_nettype wire

// ===== rtl/rpt_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rpt_datapath: rectangle registers, patch walker and output register
// Holds the tile origins, clips each tile to the rectangle and drives
// the result channel.
// ----------------------------------------------------------------------------
module rpt_datapath
  import rpt_pkg::*;
(
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire rpt_cmd_t                     cmd_i,
  output rpt_sts_t                          sts_o,
  input  wire logic [PSIZE_BITS-1:0]        pw_i,
  input  wire logic [PSIZE_BITS-1:0]        ph_i,
  input  wire logic signed [COORD_BITS-1:0] rect_x_i,
  input  wire logic signed [COORD_BITS-1:0] rect_y_i,
  input  wire logic [LEN_BITS-1:0]          rect_width_i,
  input  wire logic [LEN_BITS-1:0]          rect_height_i,
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output logic signed [OUT_BITS-1:0]        patch_x_o,
  output logic signed [OUT_BITS-1:0]        patch_y_o,
  output logic [PSIZE_BITS-1:0]             patch_w_o,
  output logic [PSIZE_BITS-1:0]             patch_h_o,
  output logic                              last_patch_o,
  output logic                              truncated_o
);

  localparam int PAD_C = ARITH_BITS - COORD_BITS;
  localparam int PAD_L = ARITH_BITS - LEN_BITS;
  localparam int PAD_P = ARITH_BITS - PSIZE_BITS;

  logic [COORD_BITS-1:0]          x_q, y_q;
  logic signed [ARITH_BITS-1:0]   end_x_q, end_y_q;
  logic signed [ARITH_BITS-1:0]   first_x_q;
  logic signed [ARITH_BITS-1:0]   org_x_q, org_y_q;
  logic [CNT_BITS-1:0]            cnt_q;

  logic                           out_valid_q;
  logic [OUT_BITS-1:0]            patch_x_q, patch_y_q;
  logic [PSIZE_BITS-1:0]          patch_w_q, patch_h_q;
  logic                           last_q, trunc_q;

  logic signed [ARITH_BITS-1:0]   in_x_ext, in_y_ext;
  logic signed [ARITH_BITS-1:0]   x_ext, y_ext;
  logic signed [ARITH_BITS-1:0]   pw_ext, ph_ext;
  logic [COORD_BITS-1:0]          mag_x, mag_y;
  logic                           div_done;
  logic [PSIZE_BITS-1:0]          div_rem;
  logic [PSIZE_BITS-1:0]          mod_x, mod_y;
  logic signed [ARITH_BITS-1:0]   org_x_next, org_y_next;
  logic signed [ARITH_BITS-1:0]   lo_x, lo_y, hi_x, hi_y;
  logic signed [ARITH_BITS-1:0]   size_x, size_y;
  logic                           col_end, row_end, final_tile, cnt_last, last_now;
  logic                           out_free;

  assign in_x_ext = $signed({{PAD_C{rect_x_i[COORD_BITS-1]}}, rect_x_i});
  assign in_y_ext = $signed({{PAD_C{rect_y_i[COORD_BITS-1]}}, rect_y_i});
  assign x_ext    = $signed({{PAD_C{x_q[COORD_BITS-1]}}, x_q});
  assign y_ext    = $signed({{PAD_C{y_q[COORD_BITS-1]}}, y_q});
  assign pw_ext   = $signed({{PAD_P{1'b0}}, pw_i});
  assign ph_ext   = $signed({{PAD_P{1'b0}}, ph_i});

  // magnitudes for the divider; the most negative value maps to its own pattern
  assign mag_x = x_q[COORD_BITS-1] ? (~x_q + 1'b1) : x_q;
  assign mag_y = y_q[COORD_BITS-1] ? (~y_q + 1'b1) : y_q;

  rpt_divider u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (cmd_i.div_sel_y ? mag_y : mag_x),
    .divisor_i  (cmd_i.div_sel_y ? ph_i : pw_i),
    .done_o     (div_done),
    .rem_o      (div_rem)
  );

  // floor modulo: negative coordinates with a remainder wrap to p - rem
  assign mod_x = (x_q[COORD_BITS-1] && div_rem != '0) ? (pw_i - div_rem) : div_rem;
  assign mod_y = (y_q[COORD_BITS-1] && div_rem != '0) ? (ph_i - div_rem) : div_rem;

  assign org_x_next = org_x_q + pw_ext;
  assign org_y_next = org_y_q + ph_ext;
  assign col_end    = (org_x_next >= end_x_q);
  assign row_end    = (org_y_next >= end_y_q);

  assign lo_x   = (org_x_q > x_ext) ? org_x_q : x_ext;
  assign lo_y   = (org_y_q > y_ext) ? org_y_q : y_ext;
  assign hi_x   = (org_x_next < end_x_q) ? org_x_next : end_x_q;
  assign hi_y   = (org_y_next < end_y_q) ? org_y_next : end_y_q;
  assign size_x = hi_x - lo_x;
  assign size_y = hi_y - lo_y;

  assign final_tile = col_end && row_end;
  assign cnt_last   = (cnt_q == CNT_BITS'(MAX_PATCHES - 1));
  assign last_now   = final_tile || cnt_last;

  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
    end else begin
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (cmd_i.load) begin
        cnt_q <= '0;
      end else if (cmd_i.emit) begin
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      x_q       <= rect_x_i;
      y_q       <= rect_y_i;
      end_x_q   <= in_x_ext + $signed({{PAD_L{1'b0}}, rect_width_i});
      end_y_q   <= in_y_ext + $signed({{PAD_L{1'b0}}, rect_height_i});
      first_x_q <= in_x_ext;
      org_x_q   <= in_x_ext;
      org_y_q   <= in_y_ext;
    end
    if (cmd_i.set_first_x) begin
      first_x_q <= x_ext - $signed({{PAD_P{1'b0}}, mod_x});
      org_x_q   <= x_ext - $signed({{PAD_P{1'b0}}, mod_x});
    end
    if (cmd_i.set_first_y) begin
      org_y_q <= y_ext - $signed({{PAD_P{1'b0}}, mod_y});
    end
    if (cmd_i.emit) begin
      patch_x_q <= lo_x[OUT_BITS-1:0];
      patch_y_q <= lo_y[OUT_BITS-1:0];
      patch_w_q <= size_x[PSIZE_BITS-1:0];
      patch_h_q <= size_y[PSIZE_BITS-1:0];
      last_q    <= last_now;
      trunc_q   <= cnt_last && !final_tile;
      // step along the row, wrap to the next row at the right edge
      if (col_end) begin
        org_x_q <= first_x_q;
        org_y_q <= org_y_next;
      end else begin
        org_x_q <= org_x_next;
      end
    end
  end

  always_comb begin
    sts_o            = '0;
    sts_o.in_empty   = (rect_width_i == '0) || (rect_height_i == '0);
    sts_o.div_done   = div_done;
    sts_o.out_free   = out_free;
    sts_o.last_patch = last_now;
  end

  assign out_valid_o  = out_valid_q;
  assign patch_x_o    = $signed(patch_x_q);
  assign patch_y_o    = $signed(patch_y_q);
  assign patch_w_o    = patch_w_q;
  assign patch_h_o    = patch_h_q;
  assign last_patch_o = last_q;
  assign truncated_o  = trunc_q;

endmodule
`default_nettype wire

// ===== rtl/rect_patch_tiler_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rect_patch_tiler_top: splits a rectangle into covering patches
// A rectangle item enters on the input channel (valid/stall); the covering
// patches leave on the result channel (valid/stall), row by row, top to
// bottom and left to right, the final one flagged by last_patch_o and, if
// the emit limit of 64 cut the list short, by truncated_o.
// Patch size and tiling mode are written through the cfg channel (valid/
// ready, ready always high) only while the block is idle: the user is bound
// to this, the block itself does not enforce it. In tight mode the block
// goes straight from the taken item to the patch walk; in grid mode the two
// origin alignments first run, one after the other, on one bit-serial
// remainder unit. Then one patch per cycle while the result channel does
// not stall, up to 64 per item. An empty rectangle is taken and gives
// nothing.
// The input stalls while a rectangle is in work; a result stall holds the
// output register and the patch walk waits. A new rectangle is taken while
// the last patch of the previous one still waits to leave.
// Reset empties the output register, returns to idle and loads the patch
// size 256 x 256 in grid mode.
// ----------------------------------------------------------------------------
module rect_patch_tiler_top
  import rpt_pkg::*;
(
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_valid_i,
  output logic                              cfg_ready_o,
  input  wire logic [CFG_IDX_BITS-1:0]      cfg_index_i,
  input  wire logic [PSIZE_BITS-1:0]        cfg_data_i,
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire logic signed [COORD_BITS-1:0] rect_x_i,
  input  wire logic signed [COORD_BITS-1:0] rect_y_i,
  input  wire logic [LEN_BITS-1:0]          rect_width_i,
  input  wire logic [LEN_BITS-1:0]          rect_height_i,
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output logic signed [OUT_BITS-1:0]        patch_x_o,
  output logic signed [OUT_BITS-1:0]        patch_y_o,
  output logic [PSIZE_BITS-1:0]             patch_w_o,
  output logic [PSIZE_BITS-1:0]             patch_h_o,
  output logic                              last_patch_o,
  output logic                              truncated_o
);

  logic [PSIZE_BITS-1:0] pw_q, ph_q;
  logic                  mode_q;
  logic [PSIZE_BITS-1:0] pw_eff, ph_eff;
  rpt_cmd_t              cmd;
  rpt_sts_t              sts;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pw_q   <= PATCH_SIZE_RESET;
      ph_q   <= PATCH_SIZE_RESET;
      mode_q <= MODE_GRID;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_PATCH_WIDTH:  pw_q   <= cfg_data_i;
        CFG_PATCH_HEIGHT: ph_q   <= cfg_data_i;
        CFG_TILING_MODE:  mode_q <= cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  // a zero patch size acts as one pixel
  assign pw_eff = (pw_q == '0) ? PSIZE_BITS'(1) : pw_q;
  assign ph_eff = (ph_q == '0) ? PSIZE_BITS'(1) : ph_q;

  rpt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .mode_i     (mode_q),
    .sts_i      (sts),
    .in_stall_o (in_stall_o),
    .cmd_o      (cmd)
  );

  rpt_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .pw_i          (pw_eff),
    .ph_i          (ph_eff),
    .rect_x_i      (rect_x_i),
    .rect_y_i      (rect_y_i),
    .rect_width_i  (rect_width_i),
    .rect_height_i (rect_height_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .patch_x_o     (patch_x_o),
    .patch_y_o     (patch_y_o),
    .patch_w_o     (patch_w_o),
    .patch_h_o     (patch_h_o),
    .last_patch_o  (last_patch_o),
    .truncated_o   (truncated_o)
  );

endmodule
`default_nettype wire

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for rect_patch_tiler_top
// Rectangles are pushed through the valid/stall input channel and every
// accepted one is tiled by a local predictor into the patches it should
// produce. The monitor checks each patch leaving the block against the
// oldest of them. Patch size and tiling mode are changed between phases
// while the block is idle. Both channels idle at random.
// ----------------------------------------------------------------------------
module tb;
  import rpt_pkg::*;

  localparam logic [CFG_IDX_BITS-1:0] CFG_UNMAPPED = 2'd3;
  localparam int RAND_PHASES = 9;
  localparam int PHASE_ITEMS = 50;
  localparam int SETTLE_CYCLES = 100;

  typedef struct {
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
    logic [LEN_BITS-1:0]          w;
    logic [LEN_BITS-1:0]          h;
  } rect_t;

  typedef struct {
    logic signed [OUT_BITS-1:0] px;
    logic signed [OUT_BITS-1:0] py;
    logic [PSIZE_BITS-1:0]      pw;
    logic [PSIZE_BITS-1:0]      ph;
    logic                       last;
    logic                       trunc;
  } patch_t;

  logic                         clk_i = 1'b0;
  logic                         rst_ni = 1'b0;
  logic                         cfg_valid_i = 1'b0;
  logic                         cfg_ready_o;
  logic [CFG_IDX_BITS-1:0]      cfg_index_i = CFG_PATCH_WIDTH;
  logic [PSIZE_BITS-1:0]        cfg_data_i = '0;
  logic                         in_valid_i = 1'b0;
  logic                         in_stall_o;
  logic signed [COORD_BITS-1:0] rect_x_i = '0;
  logic signed [COORD_BITS-1:0] rect_y_i = '0;
  logic [LEN_BITS-1:0]          rect_width_i = '0;
  logic [LEN_BITS-1:0]          rect_height_i = '0;
  logic                         out_valid_o;
  logic                         out_stall_i = 1'b0;
  logic signed [OUT_BITS-1:0]   patch_x_o;
  logic signed [OUT_BITS-1:0]   patch_y_o;
  logic [PSIZE_BITS-1:0]        patch_w_o;
  logic [PSIZE_BITS-1:0]        patch_h_o;
  logic                         last_patch_o;
  logic                         truncated_o;

  rect_t  rect_backlog[$];
  patch_t expected_patches[$];
  int     errors = 0;
  int     tx_idle_pct = 34;
  int     rx_idle_pct = 78;

  // local copy of the block's registers
  logic [PSIZE_BITS-1:0] cur_pw = PATCH_SIZE_RESET;
  logic [PSIZE_BITS-1:0] cur_ph = PATCH_SIZE_RESET;
  logic                  cur_mode = MODE_GRID;

  rect_patch_tiler_top dut (.*);

  always #6 clk_i = ~clk_i;

  function automatic longint floor_quot(input longint a, input longint b);
    longint q;
    q = a / b;
    if ((a % b) != 0 && a < 0) q--;
    return q;
  endfunction

  // tile count along one axis and the origin of its first tile
  function automatic longint span_tiles(input longint pos, input longint len,
                                        input longint p, output longint first);
    longint c0;
    if (cur_mode == MODE_TIGHT) begin
      first = pos;
      return (len + p - 1) / p;
    end
    c0 = floor_quot(pos, p);
    first = c0 * p;
    return floor_quot(pos + len - 1, p) - c0 + 1;
  endfunction

  // tile k along one axis clipped to the rectangle
  function automatic longint clip_tile(input longint pos, input longint len, input longint p,
                                       input longint first, input longint k,
                                       output longint size);
    longint org, lo, hi;
    org = first + k * p;
    lo = (org > pos) ? org : pos;
    hi = (org + p < pos + len) ? org + p : pos + len;
    size = hi - lo;
    return lo;
  endfunction

  // queue up the patches that cover one rectangle
  task automatic tile_rect(input logic signed [COORD_BITS-1:0] rx,
                           input logic signed [COORD_BITS-1:0] ry,
                           input logic [LEN_BITS-1:0] rw, input logic [LEN_BITS-1:0] rh);
    longint x, y, w, h, pw, ph, fx, fy, nc, nr, sw, sh, px, py;
    int     n;
    bit     cut;
    patch_t p;
    x = rx;
    y = ry;
    w = rw;
    h = rh;
    pw = (cur_pw == 0) ? 1 : cur_pw;
    ph = (cur_ph == 0) ? 1 : cur_ph;
    n = 0;
    cut = 1'b0;
    if (w == 0 || h == 0) return;
    nc = span_tiles(x, w, pw, fx);
    nr = span_tiles(y, h, ph, fy);
    for (longint r = 0; r < nr && !cut; r++) begin
      for (longint c = 0; c < nc; c++) begin
        if (n >= MAX_PATCHES) begin
          cut = 1'b1;
          break;
        end
        px = clip_tile(x, w, pw, fx, c, sw);
        py = clip_tile(y, h, ph, fy, r, sh);
        p.px = px[OUT_BITS-1:0];
        p.py = py[OUT_BITS-1:0];
        p.pw = sw[PSIZE_BITS-1:0];
        p.ph = sh[PSIZE_BITS-1:0];
        p.last = 1'b0;
        p.trunc = 1'b0;
        expected_patches.push_back(p);
        n++;
      end
    end
    if (n > 0) begin
      p = expected_patches.pop_back();
      p.last = 1'b1;
      p.trunc = cut;
      expected_patches.push_back(p);
    end
  endtask

  // rectangle driver
  always @(posedge clk_i or negedge rst_ni) begin
    rect_t r;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o)
        tile_rect(rect_x_i, rect_y_i, rect_width_i, rect_height_i);
      if (!in_valid_i || !in_stall_o) begin
        if (rect_backlog.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
          r = rect_backlog.pop_front();
          in_valid_i <= 1'b1;
          rect_x_i <= r.x;
          rect_y_i <= r.y;
          rect_width_i <= r.w;
          rect_height_i <= r.h;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(input string name, input logic signed [OUT_BITS:0] want,
                             input logic signed [OUT_BITS:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  // patch monitor
  always @(posedge clk_i or negedge rst_ni) begin
    patch_t e;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_patches.size() == 0) begin
          $error("patch with none expected: x %0d y %0d", patch_x_o, patch_y_o);
          errors++;
        end else begin
          e = expected_patches.pop_front();
          check_field("patch_x", e.px, patch_x_o);
          check_field("patch_y", e.py, patch_y_o);
          check_field("patch_w", e.pw, patch_w_o);
          check_field("patch_h", e.ph, patch_h_o);
          check_field("last_patch", e.last, last_patch_o);
          check_field("truncated", e.trunc, truncated_o);
        end
      end
      out_stall_i <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  task automatic add_rect(input int x, input int y, input int w, input int h);
    rect_t r;
    r.x = x[COORD_BITS-1:0];
    r.y = y[COORD_BITS-1:0];
    r.w = w[LEN_BITS-1:0];
    r.h = h[LEN_BITS-1:0];
    rect_backlog.push_back(r);
  endtask

  // wait until every item is in and every patch is out, then let the block settle
  // sampled mid-cycle so the driver's updates of this cycle are already visible
  task automatic drain();
    while (rect_backlog.size() != 0 || in_valid_i || expected_patches.size() != 0)
      @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // caller lowers cfg_valid_i after the last write of a group
  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [PSIZE_BITS-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      CFG_PATCH_WIDTH:  cur_pw = val;
      CFG_PATCH_HEIGHT: cur_ph = val;
      CFG_TILING_MODE:  cur_mode = val[0];
      default: ;
    endcase
  endtask

  function automatic logic [PSIZE_BITS-1:0] pick_size(input int k);
    case (k % 4)
      0: return PSIZE_BITS'($urandom_range(1, 8));
      1: return PSIZE_BITS'($urandom_range(9, 300));
      2: return PSIZE_BITS'($urandom_range(301, 8191));
      default: return $urandom_range(0, 1) ? '0 : PSIZE_BITS'($urandom);
    endcase
  endfunction

  // lengths of up to three tiles so most rectangles stay under the emit limit
  function automatic int pick_len(input logic [PSIZE_BITS-1:0] p);
    int lim;
    lim = 3 * ((p == 0) ? 1 : int'(p));
    if (lim > 32767) lim = 32767;
    return $urandom_range(1, lim);
  endfunction

  initial begin
    logic [PSIZE_BITS-1:0] mode_word;
    int k, w, h;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset setting: 256 x 256 grid
    add_rect(0, 0, 1, 1);
    add_rect(-32768, -32768, 1, 1);
    add_rect(32767, 32767, 1, 1);
    add_rect(-1, -1, 2, 2);
    add_rect(100, 0, 0, 50);
    add_rect(0, 100, 50, 0);
    add_rect(0, 0, 2048, 2048);
    add_rect(0, 0, 3328, 1280);
    add_rect(-32768, -32768, 32767, 32767);
    add_rect(-5, 7, 600, 300);
    drain();

    // unmapped index is dropped; zero patch size acts as one
    write_reg(CFG_UNMAPPED, 13'd5);
    write_reg(CFG_TILING_MODE, {12'd0, MODE_TIGHT});
    write_reg(CFG_PATCH_WIDTH, '0);
    write_reg(CFG_PATCH_HEIGHT, '0);
    cfg_valid_i <= 1'b0;
    add_rect(32767, 32767, 32767, 1);
    add_rect(-3, -3, 8, 8);
    add_rect(-32768, 0, 1, 1);
    add_rect(0, 0, 9, 8);
    drain();

    // oversized patches
    write_reg(CFG_PATCH_WIDTH, 13'd8191);
    write_reg(CFG_PATCH_HEIGHT, 13'd4096);
    write_reg(CFG_TILING_MODE, {12'd0, MODE_GRID});
    cfg_valid_i <= 1'b0;
    add_rect(-32768, -32768, 32767, 32767);
    add_rect(100, -100, 20000, 5000);
    drain();
    write_reg(CFG_TILING_MODE, {12'd0, MODE_TIGHT});
    cfg_valid_i <= 1'b0;
    add_rect(32767, -32768, 32767, 32767);
    add_rect(0, 0, 1, 32767);
    add_rect(-1, 5, 8191, 4097);
    drain();

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      case (ph / 3)
        0: begin
          tx_idle_pct = 34;
          rx_idle_pct = 78;
        end
        1: begin
          tx_idle_pct = 78;
          rx_idle_pct = 34;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase
      mode_word = PSIZE_BITS'($urandom);
      mode_word[0] = (ph % 2 == 0) ? MODE_GRID : MODE_TIGHT;
      write_reg(CFG_PATCH_WIDTH, pick_size(ph));
      write_reg(CFG_PATCH_HEIGHT, pick_size(ph + 1));
      write_reg(CFG_TILING_MODE, mode_word);
      cfg_valid_i <= 1'b0;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        k = $urandom_range(0, 9);
        if (k == 0) begin
          w = $urandom_range(0, 32767);
          h = $urandom_range(0, 32767);
        end else if (k == 1) begin
          w = $urandom_range(0, 1) ? 0 : $urandom_range(0, 32767);
          h = (w == 0) ? $urandom_range(0, 32767) : 0;
        end else begin
          w = pick_len(cur_pw);
          h = pick_len(cur_ph);
        end
        add_rect($urandom_range(0, 65535), $urandom_range(0, 65535), w, h);
      end
      drain();
    end

    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #30000000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
